>>> rtl/core/tcgr_pkg.sv
// Shared types and constants of the text console glyph renderer.
package tcgr_pkg;

  // Fixed widths (cover the whole legal parameter range)
  localparam int COL_W      = 7;   // byte column index, also cursor_col >> 1
  localparam int IDX_W      = 8;   // byte index inside a walk
  localparam int OFF_W      = 12;  // byte offset inside a column, before range check
  localparam int LIN_W      = 18;  // linear framebuffer address before range check
  localparam int FBASE_W    = 11;  // font row address
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  // Command function codes
  localparam logic [2:0] FUNC_DRAW   = 3'd0;
  localparam logic [2:0] FUNC_CLEAR  = 3'd1;
  localparam logic [2:0] FUNC_INVERT = 3'd2;
  localparam logic [2:0] FUNC_SETCOL = 3'd3;
  localparam logic [2:0] FUNC_SETROW = 3'd4;
  localparam logic [2:0] FUNC_READ   = 3'd5;
  localparam logic [2:0] FUNC_LOAD   = 3'd6;

  // Character codes
  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] FIRST_GLYPH  = 8'h20;

  // Framebuffer walk kinds
  localparam logic [2:0] OP_DRAW   = 3'd0;
  localparam logic [2:0] OP_CLEAR  = 3'd1;
  localparam logic [2:0] OP_INVERT = 3'd2;
  localparam logic [2:0] OP_SCROLL = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  // What a decoded item needs next
  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_WALK  = 2'd1;
  localparam logic [1:0] KIND_CHECK = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 3'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic decode;
    logic rd;
    logic wr;
    logic scroll_start;
    logic load_out;
    logic clr_wr;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] kind;
    logic       last;
    logic       op_draw;
    logic       need_scroll;
    logic       clr_last;
  } dp_stat_t;

  // Result item, read_data in the lowest bits
  typedef struct packed {
    logic       ignored;
    logic       did_scroll;
    logic [7:0] cursor_line;
    logic [7:0] cursor_column;
    logic [7:0] read_data;
  } result_t;

endpackage

>>> rtl/core/tcgr_ctrl.sv
// Command sequencer of the text console glyph renderer.
module tcgr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                out_tready,
  output logic                out_tvalid,
  input  tcgr_pkg::dp_stat_t  stat,
  output tcgr_pkg::ctl_cmd_t  cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DECODE = 3'd2;
  localparam logic [2:0] ST_RD     = 3'd3;
  localparam logic [2:0] ST_WR     = 3'd4;
  localparam logic [2:0] ST_CHECK  = 3'd5;
  localparam logic [2:0] ST_PUSH   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        case (stat.kind)
          tcgr_pkg::KIND_WALK:  state_nxt = ST_RD;
          tcgr_pkg::KIND_CHECK: state_nxt = ST_CHECK;
          default:              state_nxt = ST_PUSH;
        endcase
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        cmd.wr = 1'b1;
        if (stat.last) begin
          state_nxt = stat.op_draw ? ST_CHECK : ST_PUSH;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_CHECK: begin
        if (stat.need_scroll) begin
          cmd.scroll_start = 1'b1;
          state_nxt        = ST_RD;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

>>> rtl/core/tcgr_dp.sv
// Datapath of the text console glyph renderer: cursor, registers, stores, byte walker.
module tcgr_dp #(
  parameter int BYTE_COLUMNS = 40,
  parameter int COLUMN_BYTES = 128,
  parameter int LINE_BYTES   = 6,
  parameter int GLYPH_COUNT  = 96,
  parameter int GLYPH_ROWS   = 5
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [2:0]                           in_tuser,
  input  logic [tcgr_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                 cfg_valid,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  tcgr_pkg::ctl_cmd_t                   cmd,
  output tcgr_pkg::dp_stat_t                   stat,
  output tcgr_pkg::result_t                    res
);

  localparam int FB_SIZE   = BYTE_COLUMNS * COLUMN_BYTES;
  localparam int FB_AW     = $clog2(FB_SIZE);
  localparam int FONT_SIZE = GLYPH_COUNT * GLYPH_ROWS;
  localparam int FONT_AW   = (FONT_SIZE > 1) ? $clog2(FONT_SIZE) : 1;

  localparam int COL_W   = tcgr_pkg::COL_W;
  localparam int IDX_W   = tcgr_pkg::IDX_W;
  localparam int OFF_W   = tcgr_pkg::OFF_W;
  localparam int LIN_W   = tcgr_pkg::LIN_W;
  localparam int FBASE_W = tcgr_pkg::FBASE_W;

  // Stores
  logic [7:0] fb_mem   [FB_SIZE];
  logic [3:0] font_mem [FONT_SIZE];
  logic [7:0] fb_q_r;
  logic [3:0] font_q_r;

  // Configuration and cursor
  logic       inv_r;
  logic [6:0] left_r;
  logic [6:0] right_r;
  logic [4:0] bottom_r;
  logic [7:0] cursor_col_r;
  logic [7:0] cursor_row_r;
  logic [FB_AW-1:0] clr_addr_r;

  // Captured item
  logic [2:0]  func_r;
  logic [7:0]  code_r;
  logic [4:0]  line_r;
  logic [7:0]  cval_r;
  logic [12:0] addr_r;
  logic [8:0]  fidx_r;
  logic [3:0]  frow_r;

  // Walker
  logic [2:0]         op_r;
  logic [COL_W-1:0]   col_r;
  logic [IDX_W-1:0]   idx_r;
  logic [OFF_W-1:0]   base_r;
  logic [FBASE_W-1:0] fbase_r;
  logic [FB_AW-1:0]   wr_addr_r;
  logic               wr_ok_r;
  logic               src_ok_r;

  // Result accumulation
  logic [7:0] rdata_r;
  logic       scrolled_r;
  logic       ign_r;

  logic [OFF_W-1:0]   off;
  logic               cell_ok;
  logic               src_ok;
  logic [LIN_W-1:0]   lin_dst;
  logic [LIN_W-1:0]   lin_src;
  logic [LIN_W-1:0]   lin_rd;
  logic [FB_AW-1:0]   fb_raddr;
  logic [FONT_AW-1:0] font_raddr;
  logic               glyph_ok;
  logic               font_ok;
  logic               read_ok;
  logic               ign_dec;
  logic [1:0]         kind;
  logic               last;
  logic [IDX_W-1:0]   inner_lim;
  logic [3:0]         px;
  logic [7:0]         fill;
  logic [7:0]         wdata;
  logic               fb_we;
  logic [FB_AW-1:0]   fb_waddr;
  logic [7:0]         fb_wdata;
  logic               font_we;
  logic [7:0]         col_inc;

  // Address generation and range checks
  assign off     = base_r + OFF_W'(idx_r);
  assign cell_ok = (col_r < COL_W'(BYTE_COLUMNS)) && (off < OFF_W'(COLUMN_BYTES));
  assign src_ok  = (OFF_W'(idx_r) + OFF_W'(LINE_BYTES)) < OFF_W'(COLUMN_BYTES);
  assign lin_dst = LIN_W'(col_r) * LIN_W'(COLUMN_BYTES) + LIN_W'(off);
  assign lin_src = lin_dst + LIN_W'(LINE_BYTES);

  always_comb begin
    case (op_r)
      tcgr_pkg::OP_READ:   lin_rd = LIN_W'(addr_r);
      tcgr_pkg::OP_SCROLL: lin_rd = lin_src;
      default:             lin_rd = lin_dst;
    endcase
  end

  assign fb_raddr   = lin_rd[FB_AW-1:0];
  assign font_raddr = FONT_AW'(fbase_r + FBASE_W'(idx_r));

  // Item decode
  assign glyph_ok = (code_r >= tcgr_pkg::FIRST_GLYPH) &&
                    ({1'b0, code_r} < (9'(GLYPH_COUNT) + {1'b0, tcgr_pkg::FIRST_GLYPH}));
  assign font_ok  = FBASE_W'(fidx_r) < FBASE_W'(FONT_SIZE);
  assign read_ok  = LIN_W'(addr_r) < LIN_W'(FB_SIZE);

  always_comb begin
    kind    = tcgr_pkg::KIND_DONE;
    ign_dec = 1'b0;
    unique case (func_r) inside
      tcgr_pkg::FUNC_DRAW: begin
        if (code_r == tcgr_pkg::CHAR_NEWLINE) begin
          kind = tcgr_pkg::KIND_CHECK;
        end else if (glyph_ok) begin
          kind = tcgr_pkg::KIND_WALK;
        end else if (code_r != tcgr_pkg::CHAR_NUL) begin
          ign_dec = 1'b1;
        end
      end
      tcgr_pkg::FUNC_CLEAR, tcgr_pkg::FUNC_INVERT: kind = tcgr_pkg::KIND_WALK;
      tcgr_pkg::FUNC_SETCOL, tcgr_pkg::FUNC_SETROW: kind = tcgr_pkg::KIND_DONE;
      tcgr_pkg::FUNC_READ: begin
        if (read_ok) begin
          kind = tcgr_pkg::KIND_WALK;
        end else begin
          ign_dec = 1'b1;
        end
      end
      tcgr_pkg::FUNC_LOAD: ign_dec = !font_ok;
      default: ign_dec = 1'b1;
    endcase
  end

  // Walk end and inner loop limit
  always_comb begin
    inner_lim = (op_r == tcgr_pkg::OP_SCROLL) ? IDX_W'(COLUMN_BYTES - 1) : IDX_W'(LINE_BYTES - 1);
    case (op_r)
      tcgr_pkg::OP_DRAW: last = (idx_r == IDX_W'(GLYPH_ROWS - 1));
      tcgr_pkg::OP_READ: last = 1'b1;
      default:           last = (col_r == COL_W'(BYTE_COLUMNS - 1)) && (idx_r == inner_lim);
    endcase
  end

  // Byte to write back
  assign px   = font_q_r ^ {4{inv_r}};
  assign fill = {8{inv_r}};

  always_comb begin
    case (op_r)
      tcgr_pkg::OP_DRAW:   wdata = cursor_col_r[0] ? {px, fb_q_r[3:0]} : {fb_q_r[7:4], px};
      tcgr_pkg::OP_CLEAR:  wdata = fill;
      tcgr_pkg::OP_INVERT: wdata = ~fb_q_r;
      tcgr_pkg::OP_SCROLL: wdata = src_ok_r ? fb_q_r : fill;
      default:             wdata = fb_q_r;
    endcase
  end

  assign fb_we    = cmd.clr_wr || (cmd.wr && wr_ok_r && (op_r != tcgr_pkg::OP_READ));
  assign fb_waddr = cmd.clr_wr ? clr_addr_r : wr_addr_r;
  assign fb_wdata = cmd.clr_wr ? 8'h00 : wdata;
  assign font_we  = cmd.decode && (func_r == tcgr_pkg::FUNC_LOAD) && font_ok;
  assign col_inc  = cursor_col_r + 8'd1;

  // Framebuffer: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (fb_we) begin
      fb_mem[fb_waddr] <= fb_wdata;
    end
    fb_q_r <= fb_mem[fb_raddr];
  end

  // Font store
  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[FONT_AW'(fidx_r)] <= frow_r;
    end
    font_q_r <= font_mem[font_raddr];
  end

  // Configuration, cursor and clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r        <= 1'b0;
      left_r       <= 7'd0;
      right_r      <= 7'd79;
      bottom_r     <= 5'd20;
      cursor_col_r <= 8'd0;
      cursor_row_r <= 8'd0;
      clr_addr_r   <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          tcgr_pkg::CFG_INVERT: inv_r    <= cfg_data[0];
          tcgr_pkg::CFG_LEFT:   left_r   <= cfg_data[6:0];
          tcgr_pkg::CFG_RIGHT:  right_r  <= cfg_data[6:0];
          tcgr_pkg::CFG_BOTTOM: bottom_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.decode) begin
        if (func_r == tcgr_pkg::FUNC_SETCOL) begin
          cursor_col_r <= cval_r;
        end
        if (func_r == tcgr_pkg::FUNC_SETROW) begin
          cursor_row_r <= cval_r;
        end
        if (func_r == tcgr_pkg::FUNC_DRAW && code_r == tcgr_pkg::CHAR_NEWLINE) begin
          cursor_row_r <= cursor_row_r + 8'd1;
          cursor_col_r <= 8'd0;
        end
      end
      // cursor advance after a glyph, line back up after a scroll
      if (cmd.wr && last) begin
        if (op_r == tcgr_pkg::OP_DRAW) begin
          if (col_inc > {1'b0, right_r}) begin
            cursor_row_r <= cursor_row_r + 8'd1;
            cursor_col_r <= {1'b0, left_r};
          end else begin
            cursor_col_r <= col_inc;
          end
        end
        if (op_r == tcgr_pkg::OP_SCROLL) begin
          cursor_row_r <= cursor_row_r - 8'd1;
        end
      end
    end
  end

  // Item capture, walker and result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_tuser;
      code_r <= in_tdata[7:0];
      line_r <= in_tdata[12:8];
      cval_r <= in_tdata[20:13];
      addr_r <= in_tdata[33:21];
      fidx_r <= in_tdata[42:34];
      frow_r <= in_tdata[46:43];
    end
    if (cmd.decode) begin
      rdata_r    <= 8'h00;
      scrolled_r <= 1'b0;
      ign_r      <= ign_dec;
      idx_r      <= '0;
      fbase_r    <= FBASE_W'(code_r - tcgr_pkg::FIRST_GLYPH) * FBASE_W'(GLYPH_ROWS);
      case (func_r) inside
        tcgr_pkg::FUNC_DRAW: begin
          op_r   <= tcgr_pkg::OP_DRAW;
          col_r  <= cursor_col_r[7:1];
          base_r <= OFF_W'(cursor_row_r) * OFF_W'(LINE_BYTES);
        end
        tcgr_pkg::FUNC_CLEAR, tcgr_pkg::FUNC_INVERT: begin
          op_r   <= (func_r == tcgr_pkg::FUNC_CLEAR) ? tcgr_pkg::OP_CLEAR : tcgr_pkg::OP_INVERT;
          col_r  <= '0;
          base_r <= OFF_W'(line_r) * OFF_W'(LINE_BYTES);
        end
        default: begin
          op_r   <= tcgr_pkg::OP_READ;
          col_r  <= '0;
          base_r <= '0;
        end
      endcase
    end
    if (cmd.scroll_start) begin
      op_r       <= tcgr_pkg::OP_SCROLL;
      col_r      <= '0;
      idx_r      <= '0;
      base_r     <= '0;
      scrolled_r <= 1'b1;
    end
    // read phase: hold target address and checks for the write phase
    if (cmd.rd) begin
      wr_addr_r <= lin_dst[FB_AW-1:0];
      wr_ok_r   <= cell_ok;
      src_ok_r  <= src_ok;
    end
    // write phase: drop accounting and step
    if (cmd.wr) begin
      if (!wr_ok_r && (op_r == tcgr_pkg::OP_DRAW || op_r == tcgr_pkg::OP_CLEAR ||
                       op_r == tcgr_pkg::OP_INVERT)) begin
        ign_r <= 1'b1;
      end
      if (op_r == tcgr_pkg::OP_READ) begin
        rdata_r <= fb_q_r;
      end
      if (op_r == tcgr_pkg::OP_DRAW || idx_r != inner_lim) begin
        idx_r <= idx_r + 1'b1;
      end else begin
        idx_r <= '0;
        col_r <= col_r + 1'b1;
      end
    end
    if (cmd.load_out) begin
      res.read_data     <= rdata_r;
      res.cursor_column <= cursor_col_r;
      res.cursor_line   <= cursor_row_r;
      res.did_scroll    <= scrolled_r;
      res.ignored       <= ign_r;
    end
  end

  // Status to the controller
  assign stat.kind        = kind;
  assign stat.last        = last;
  assign stat.op_draw     = (op_r == tcgr_pkg::OP_DRAW);
  assign stat.need_scroll = cursor_row_r > {3'b000, bottom_r};
  assign stat.clr_last    = (clr_addr_r == FB_AW'(FB_SIZE - 1));

endmodule

>>> rtl/core/text_console_glyph_renderer_core.sv
// Sequence: accept, decode, then for each framebuffer byte visited a registered read and
// a write back on the single framebuffer port, a scroll check after glyphs and newlines,
// then the result push. A scroll walks every framebuffer byte. One item at a time.
// Reset (rst_n low, synchronous) sets cursor and registers to their defaults, then a
// clearing pass writes zero to all BYTE_COLUMNS*COLUMN_BYTES (5120) framebuffer bytes
// before in_tready rises.
module text_console_glyph_renderer_core #(
  parameter int BYTE_COLUMNS = 40,
  parameter int COLUMN_BYTES = 128,
  parameter int LINE_BYTES   = 6,
  parameter int GLYPH_COUNT  = 96,
  parameter int GLYPH_ROWS   = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: char_code[7:0], line_index[12:8], cursor_value[20:13], fb_address[33:21],
  //        font_index[42:34], font_row[46:43], zero[47]
  input  logic [tcgr_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: func[2:0]
  input  logic [2:0]                        in_tuser,
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: read_data[7:0], cursor_column[15:8], cursor_line[23:16], did_scroll[24],
  //        ignored[25], zero[31:26]
  output logic [tcgr_pkg::OUT_DATA_W-1:0]   out_tdata,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  tcgr_pkg::ctl_cmd_t cmd;
  tcgr_pkg::dp_stat_t stat;
  tcgr_pkg::result_t  res;

  tcgr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (stat),
    .cmd        (cmd)
  );

  tcgr_dp #(
    .BYTE_COLUMNS (BYTE_COLUMNS),
    .COLUMN_BYTES (COLUMN_BYTES),
    .LINE_BYTES   (LINE_BYTES),
    .GLYPH_COUNT  (GLYPH_COUNT),
    .GLYPH_ROWS   (GLYPH_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .res       (res)
  );

  assign cfg_ready = 1'b1;
  assign out_tdata = tcgr_pkg::OUT_DATA_W'(res);

`ifndef SYNTHESIS
  // controller issues at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.decode, cmd.rd, cmd.wr, cmd.scroll_start,
              cmd.load_out, cmd.clr_wr}))
    else $error("more than one datapath command in a cycle");

  // every write-back follows its read phase
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> $past(cmd.rd))
    else $error("framebuffer write without a preceding read");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_tvalid || out_tready))
    else $error("result register loaded while still full");

  // after an item is taken the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after an accepted item");
`endif

endmodule

>>> sim/tcgr_checker.sv
// Checker for the console renderer: tracks commands, predicts each result item, compares.
`timescale 1ns / 100ps

module tcgr_checker #(
  parameter int BYTE_COLUMNS = 40,
  parameter int COLUMN_BYTES = 128,
  parameter int LINE_BYTES   = 6,
  parameter int GLYPH_COUNT  = 96,
  parameter int GLYPH_ROWS   = 5
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [tcgr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [2:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [tcgr_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);

  localparam int FB_BYTES  = BYTE_COLUMNS * COLUMN_BYTES;
  localparam int FONT_ROWS = GLYPH_COUNT * GLYPH_ROWS;

  // Shadow of the console state
  logic [7:0] frame_mem [FB_BYTES];
  logic [3:0] font_mem  [FONT_ROWS];
  logic [7:0] cur_col;
  logic [7:0] cur_row;
  logic       inv_video;
  logic [6:0] left_col;
  logic [6:0] right_col;
  logic [4:0] bottom_row;

  tcgr_pkg::result_t awaited_results [$];
  int                mismatch_count = 0;

  assign fail_count = mismatch_count;

  function automatic logic [7:0] fill_byte();
    return inv_video ? 8'hFF : 8'h00;
  endfunction

  // Read-modify-write of one cell byte; 0 when the byte falls off the grid
  function automatic bit poke_cell(int bcol, int off, logic [7:0] keep, logic [7:0] set,
                                   bit flip);
    int a;
    if (bcol >= BYTE_COLUMNS || off >= COLUMN_BYTES) return 1'b0;
    a = bcol * COLUMN_BYTES + off;
    if (flip) frame_mem[a] = frame_mem[a] ^ 8'hFF;
    else frame_mem[a] = (frame_mem[a] & keep) | set;
    return 1'b1;
  endfunction

  // Every column moves up one text line, freed bytes take the fill
  function automatic void scroll_frame();
    logic [7:0] f;
    int base;
    f = fill_byte();
    for (int c = 0; c < BYTE_COLUMNS; c++) begin
      base = c * COLUMN_BYTES;
      for (int i = 0; i + LINE_BYTES < COLUMN_BYTES; i++)
        frame_mem[base + i] = frame_mem[base + i + LINE_BYTES];
      for (int i = COLUMN_BYTES - LINE_BYTES; i < COLUMN_BYTES; i++)
        frame_mem[base + i] = f;
    end
  endfunction

  // Clear or invert one text line; 1 if any byte was dropped
  function automatic bit sweep_line(int line, bit flip);
    bit dropped;
    logic [7:0] f;
    dropped = 1'b0;
    f = fill_byte();
    for (int c = 0; c < BYTE_COLUMNS; c++)
      for (int i = 0; i < LINE_BYTES; i++)
        if (!poke_cell(c, line * LINE_BYTES + i, 8'h00, f, flip)) dropped = 1'b1;
    return dropped;
  endfunction

  // Apply one command to the shadow state and build its result item
  function automatic tcgr_pkg::result_t render_command(logic [2:0] fn, logic [7:0] code,
                                                       logic [4:0] line, logic [7:0] cval,
                                                       logic [12:0] addr, logic [8:0] fidx,
                                                       logic [3:0] frow);
    tcgr_pkg::result_t res;
    int g;
    int bcol;
    int base;
    logic [3:0] px;
    bit moved;
    res = '0;
    moved = 1'b0;
    case (fn)
      tcgr_pkg::FUNC_DRAW: begin
        if (code == tcgr_pkg::CHAR_NUL) begin
          moved = 1'b0;
        end else if (code == tcgr_pkg::CHAR_NEWLINE) begin
          cur_row = cur_row + 8'd1;
          cur_col = 8'd0;
          moved = 1'b1;
        end else if (int'(code) >= int'(tcgr_pkg::FIRST_GLYPH) &&
                     int'(code) < int'(tcgr_pkg::FIRST_GLYPH) + GLYPH_COUNT) begin
          g = (int'(code) - int'(tcgr_pkg::FIRST_GLYPH)) * GLYPH_ROWS;
          bcol = int'(cur_col) >> 1;
          base = int'(cur_row) * LINE_BYTES;
          for (int r = 0; r < GLYPH_ROWS; r++) begin
            px = font_mem[g + r] ^ (inv_video ? 4'hF : 4'h0);
            if (cur_col[0]) begin
              if (!poke_cell(bcol, base + r, 8'h0F, {px, 4'h0}, 1'b0)) res.ignored = 1'b1;
            end else begin
              if (!poke_cell(bcol, base + r, 8'hF0, {4'h0, px}, 1'b0)) res.ignored = 1'b1;
            end
          end
          cur_col = cur_col + 8'd1;
          if (cur_col > {1'b0, right_col}) begin
            cur_row = cur_row + 8'd1;
            cur_col = {1'b0, left_col};
          end
          moved = 1'b1;
        end else begin
          res.ignored = 1'b1;
        end
        // at most one scroll per command
        if (moved && cur_row > {3'b000, bottom_row}) begin
          scroll_frame();
          cur_row = cur_row - 8'd1;
          res.did_scroll = 1'b1;
        end
      end
      tcgr_pkg::FUNC_CLEAR:  res.ignored = sweep_line(int'(line), 1'b0);
      tcgr_pkg::FUNC_INVERT: res.ignored = sweep_line(int'(line), 1'b1);
      tcgr_pkg::FUNC_SETCOL: cur_col = cval;
      tcgr_pkg::FUNC_SETROW: cur_row = cval;
      tcgr_pkg::FUNC_READ: begin
        if (int'(addr) < FB_BYTES) res.read_data = frame_mem[addr];
        else res.ignored = 1'b1;
      end
      tcgr_pkg::FUNC_LOAD: begin
        if (int'(fidx) < FONT_ROWS) font_mem[fidx] = frow;
        else res.ignored = 1'b1;
      end
      default: res.ignored = 1'b1;
    endcase
    res.cursor_column = cur_col;
    res.cursor_line = cur_row;
    return res;
  endfunction

  // Watch the three channels at each edge
  always @(posedge clk) begin
    tcgr_pkg::result_t got;
    tcgr_pkg::result_t want;
    if (!rst_n) begin
      for (int a = 0; a < FB_BYTES; a++) frame_mem[a] = 8'h00;
      for (int a = 0; a < FONT_ROWS; a++) font_mem[a] = 4'h0;
      cur_col = 8'd0;
      cur_row = 8'd0;
      inv_video = 1'b0;
      left_col = 7'd0;
      right_col = 7'd79;
      bottom_row = 5'd20;
      awaited_results.delete();
      pending <= 0;
    end else begin
      // result side first: the oldest prediction belongs to this item
      if (out_tvalid && out_tready) begin
        got = tcgr_pkg::result_t'(out_tdata[$bits(tcgr_pkg::result_t)-1:0]);
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result item 0x%08h", $realtime, out_tdata);
        end else begin
          want = awaited_results.pop_front();
          if (got.read_data !== want.read_data || got.cursor_column !== want.cursor_column ||
              got.cursor_line !== want.cursor_line || got.did_scroll !== want.did_scroll ||
              got.ignored !== want.ignored) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: result mismatch exp data=%0d col=%0d line=%0d scr=%0b ign=%0b %s",
                       $realtime, want.read_data, want.cursor_column, want.cursor_line,
                       want.did_scroll, want.ignored,
                       $sformatf("got data=%0d col=%0d line=%0d scr=%0b ign=%0b",
                                 got.read_data, got.cursor_column, got.cursor_line,
                                 got.did_scroll, got.ignored));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcgr_pkg::CFG_INVERT: inv_video = cfg_data[0];
          tcgr_pkg::CFG_LEFT:   left_col = cfg_data[6:0];
          tcgr_pkg::CFG_RIGHT:  right_col = cfg_data[6:0];
          tcgr_pkg::CFG_BOTTOM: bottom_row = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        awaited_results.push_back(render_command(in_tuser, in_tdata[7:0], in_tdata[12:8],
                                                 in_tdata[20:13], in_tdata[33:21],
                                                 in_tdata[42:34], in_tdata[46:43]));
      pending <= pending + int'(in_tvalid && in_tready) - int'(out_tvalid && out_tready);
    end
  end

endmodule

>>> sim/tb.sv
// Testbench top for the console renderer: command stimulus, register phases and verdict.
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT  = 8_000_000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 40;
  localparam int GLYPHS       = 96;
  localparam int GLYPH_ROWS   = 5;
  localparam int FONT_ROWS    = GLYPHS * GLYPH_ROWS;
  localparam logic [2:0] FUNC_NONE = 3'd7;  // unused function code

  typedef struct {
    logic [2:0]  fn;
    logic [7:0]  code;
    logic [4:0]  line;
    logic [7:0]  cval;
    logic [12:0] addr;
    logic [8:0]  fidx;
    logic [3:0]  frow;
  } console_cmd_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [tcgr_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [2:0]                      in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [tcgr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tcgr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit want_hold = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int cycles = 0;

  // stimulus-side copies used to shape commands
  logic [6:0] right_sel = 7'd79;
  logic [4:0] bottom_sel = 5'd20;
  bit         row_loaded [FONT_ROWS];
  bit         glyph_ready [GLYPHS];
  int         drawable [$];

  always #1 clk = ~clk;

  text_console_glyph_renderer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  tcgr_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Run timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("text_console_glyph_renderer_core regression: fail");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (want_hold && !hold_done) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Command with every field random
  function automatic console_cmd_t any_cmd(logic [2:0] fn);
    console_cmd_t c;
    c.fn = fn;
    c.code = 8'($urandom);
    c.line = 5'($urandom);
    c.cval = 8'($urandom);
    c.addr = 13'($urandom);
    c.fidx = 9'($urandom);
    c.frow = 4'($urandom);
    return c;
  endfunction

  // Offer one item after random idle cycles, return once it is taken
  task automatic issue(console_cmd_t c);
    int g;
    bit full;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= c.fn;
    in_tdata <= {1'b0, c.frow, c.fidx, c.addr, c.cval, c.line, c.code};
    do @(posedge clk); while (!in_tready);
    // a glyph becomes drawable once all its rows are loaded
    if (c.fn == tcgr_pkg::FUNC_LOAD && int'(c.fidx) < FONT_ROWS) begin
      row_loaded[c.fidx] = 1'b1;
      g = int'(c.fidx) / GLYPH_ROWS;
      full = 1'b1;
      for (int r = 0; r < GLYPH_ROWS; r++)
        if (!row_loaded[g * GLYPH_ROWS + r]) full = 1'b0;
      if (full && !glyph_ready[g]) begin
        glyph_ready[g] = 1'b1;
        drawable.push_back(g);
      end
    end
  endtask

  task automatic draw_code(logic [7:0] code);
    console_cmd_t c;
    c = any_cmd(tcgr_pkg::FUNC_DRAW);
    c.code = code;
    issue(c);
  endtask

  task automatic draw_glyph();
    draw_code(8'(int'(tcgr_pkg::FIRST_GLYPH) + drawable[$urandom_range(drawable.size() - 1)]));
  endtask

  task automatic put_cursor(logic [2:0] fn, logic [7:0] v);
    console_cmd_t c;
    c = any_cmd(fn);
    c.cval = v;
    issue(c);
  endtask

  task automatic line_cmd(logic [2:0] fn, logic [4:0] line);
    console_cmd_t c;
    c = any_cmd(fn);
    c.line = line;
    issue(c);
  endtask

  task automatic read_at(logic [12:0] addr);
    console_cmd_t c;
    c = any_cmd(tcgr_pkg::FUNC_READ);
    c.addr = addr;
    issue(c);
  endtask

  // Five row loads of one glyph, all ones or random
  task automatic load_glyph(int g, bit ones);
    console_cmd_t c;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      c = any_cmd(tcgr_pkg::FUNC_LOAD);
      c.fidx = 9'(g * GLYPH_ROWS + r);
      if (ones) c.frow = 4'hF;
      issue(c);
    end
  endtask

  task automatic cfg_put(logic [tcgr_pkg::CFG_IDX_W-1:0] idx,
                         logic [tcgr_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(bit inv, int left, int right, int bottom);
    cfg_put(tcgr_pkg::CFG_INVERT, tcgr_pkg::CFG_DATA_W'(inv));
    cfg_put(tcgr_pkg::CFG_LEFT, tcgr_pkg::CFG_DATA_W'(left));
    cfg_put(tcgr_pkg::CFG_RIGHT, tcgr_pkg::CFG_DATA_W'(right));
    cfg_put(tcgr_pkg::CFG_BOTTOM, tcgr_pkg::CFG_DATA_W'(bottom));
    cfg_valid <= 1'b0;
    right_sel = 7'(right);
    bottom_sel = 5'(bottom);
  endtask

  // Stop offering and wait until every predicted item has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // One random command or short command sequence
  task automatic random_step();
    console_cmd_t c;
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 28) begin
      draw_glyph();
    end else if (pick < 32) begin
      draw_code(tcgr_pkg::CHAR_NEWLINE);
    end else if (pick < 37) begin
      // no-op and unknown codes
      case ($urandom_range(2))
        0: draw_code(tcgr_pkg::CHAR_NUL);
        1: begin
          v = $urandom_range(29);
          draw_code(8'(v < 9 ? v + 1 : v + 2));
        end
        default: draw_code(8'($urandom_range(255, 128)));
      endcase
    end else if (pick < 49) begin
      line_cmd(pick < 43 ? tcgr_pkg::FUNC_CLEAR : tcgr_pkg::FUNC_INVERT,
               5'($urandom_range(99) < 85 ? $urandom_range(20) : $urandom_range(31, 21)));
    end else if (pick < 57) begin
      put_cursor(tcgr_pkg::FUNC_SETCOL,
                 8'($urandom_range(99) < 90 ? $urandom_range(79) : $urandom_range(255, 80)));
    end else if (pick < 64) begin
      put_cursor(tcgr_pkg::FUNC_SETROW, 8'($urandom_range(int'(bottom_sel))));
    end else if (pick < 78) begin
      if ($urandom_range(9) == 0) begin
        read_at(13'($urandom_range(8191, 5120)));
      end else begin
        v = $urandom_range(1) ? $urandom_range(23) : $urandom_range(127);
        read_at(13'($urandom_range(39) * 128 + v));
      end
    end else if (pick < 88) begin
      load_glyph($urandom_range(GLYPHS - 1), 1'b0);
    end else if (pick < 92) begin
      // noise: unused function, or a load anywhere in the index range
      if ($urandom_range(1)) begin
        issue(any_cmd(FUNC_NONE));
      end else begin
        c = any_cmd(tcgr_pkg::FUNC_LOAD);
        c.fidx = 9'($urandom_range(511));
        issue(c);
      end
    end else if (pick < 94) begin
      // cursor below the grid: dropped glyph, then a scroll
      put_cursor(tcgr_pkg::FUNC_SETROW, 8'($urandom_range(255, 21)));
      draw_glyph();
      put_cursor(tcgr_pkg::FUNC_SETROW, 8'($urandom_range(int'(bottom_sel))));
    end else begin
      // glyph at the right margin wraps
      put_cursor(tcgr_pkg::FUNC_SETCOL, {1'b0, right_sel});
      draw_glyph();
    end
  endtask

  task automatic run_phase(bit inv, int left, int right, int bottom, int send_pct,
                           int recv_pct, int steps, bit hold);
    wait_idle();
    set_regs(inv, left, right, bottom);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (hold) want_hold = 1'b1;
    put_cursor(tcgr_pkg::FUNC_SETCOL, 8'd0);
    put_cursor(tcgr_pkg::FUNC_SETROW, 8'd0);
    repeat (steps) random_step();
  endtask

  // Stimulus and verdict
  initial begin
    console_cmd_t c;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    set_regs(1'b0, 0, 79, 20);

    // directed: font edges, codes, cursor wrap, scroll, line edges, read edges
    load_glyph(0, 1'b0);
    load_glyph(GLYPHS - 1, 1'b1);
    c = any_cmd(tcgr_pkg::FUNC_LOAD);
    c.fidx = 9'(FONT_ROWS);
    issue(c);
    c.fidx = 9'h1FF;
    issue(c);
    draw_code(tcgr_pkg::FIRST_GLYPH);
    draw_code(8'(int'(tcgr_pkg::FIRST_GLYPH) + GLYPHS - 1));
    draw_code(tcgr_pkg::CHAR_NUL);
    draw_code(8'hFF);
    put_cursor(tcgr_pkg::FUNC_SETCOL, 8'hFF);
    draw_code(8'(int'(tcgr_pkg::FIRST_GLYPH) + GLYPHS - 1));
    put_cursor(tcgr_pkg::FUNC_SETROW, 8'd20);
    draw_code(tcgr_pkg::CHAR_NEWLINE);
    line_cmd(tcgr_pkg::FUNC_CLEAR, 5'd0);
    line_cmd(tcgr_pkg::FUNC_INVERT, 5'd20);
    line_cmd(tcgr_pkg::FUNC_INVERT, 5'd21);
    read_at(13'd0);
    read_at(13'd5119);
    read_at(13'h1FFF);
    issue(any_cmd(FUNC_NONE));

    // random phases over register settings and idle patterns
    run_phase(1'b0, 0, 79, 20, 0, 0, 14, 1'b1);
    run_phase(1'b1, 5, 12, 20, 74, 0, 11, 1'b0);
    run_phase(1'b0, 79, 0, 20, 0, 74, 9, 1'b0);
    run_phase(1'b1, 0, 79, 0, 6, 6, 6, 1'b0);
    run_phase($urandom_range(1), $urandom_range(79), $urandom_range(79), $urandom_range(20),
              0, 0, 9, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("text_console_glyph_renderer_core regression: pass");
    else
      $display("text_console_glyph_renderer_core regression: fail");
    $finish;
  end

endmodule
